// ===== hw/rtl/mtt_pkg.sv =====
// Package for the multiplexed timer table: sizes, operation and status codes, FSM states.
// No dependencies.
`default_nettype none
package mtt_pkg;
  localparam int MaxTimers  = 8;
  localparam int HandleBits = 8;
  localparam int IdxW       = $clog2(MaxTimers);
  localparam int CntW       = $clog2(MaxTimers + 1);
  localparam logic [31:0] PeriodCap = 32'h0000_fff0;
  // Handle, remaining, reload, mode.
  localparam int EntryW = HandleBits + 32 + 32 + 2;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_START   = 2'd1,
    OP_RESTART = 2'd2,
    OP_STOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_UPD_RD,
    S_UPD_CHK,
    S_MOVE_RD,
    S_MOVE_WR,
    S_APPEND,
    S_TGT_RD,
    S_TGT_CHK,
    S_MOVE2_RD,
    S_MOVE2_WR,
    S_MIN_RD,
    S_MIN_CHK,
    S_FINISH
  } state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/mtt_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module mtt_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/multiplexed_timer_table.sv =====
// Multiplexed timer table: one entry RAM swept by a sequencer.
// Uses mtt_pkg and mtt_ram.
`default_nettype none
// Accepts one request whenever busy is low. A request sweeps the table on the single RAM
// port, one pass at a time: a handle search (restart and stop), an update pass, a target
// pass (restart and stop) and a minimum pass, plus a removal move for each timer taken
// out. A start on a full table ends without a sweep, and a restart or stop of an absent
// handle ends after the handle search, each with its status. Each result is valid for one
// cycle on out_valid; the receiver cannot stall, and the final result carries out_last.
module multiplexed_timer_table
  import mtt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_op,
  input  wire logic [7:0]  in_handle,
  input  wire logic [31:0] in_period,
  input  wire logic [1:0]  in_timer_mode,
  input  wire logic [15:0] in_elapsed,
  output logic             out_valid,
  output logic             out_fired,
  output logic [7:0]       out_fired_handle,
  output logic             out_deferred,
  output logic [1:0]       out_op_status,
  output logic [15:0]      out_next_period,
  output logic             out_timer_running,
  output logic             out_last
);
  state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] i_r, i_nxt;
  logic [15:0] intv_r, intv_nxt;
  logic [1:0] op_r;
  logic [HandleBits-1:0] h_r;
  logic [31:0] per_r;
  logic [1:0] md_r;
  logic [15:0] el_r;
  logic [31:0] min_r, min_nxt;
  logic [1:0] stat_r, stat_nxt;
  // Pending fire result, held until the next fire or the finish so the final one can carry last.
  logic pend_r, pend_nxt;
  logic [7:0] pend_h_r, pend_h_nxt;
  logic pend_d_r, pend_d_nxt;

  logic we;
  logic [IdxW-1:0] addr;
  logic [EntryW-1:0] wdata, rdata;
  logic [HandleBits-1:0] rd_h;
  logic [31:0] rd_rem, rd_rel;
  logic [1:0] rd_md;
  logic [CntW-1:0] lastidx;

  mtt_ram #(.Width(EntryW), .Depth(MaxTimers)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign {rd_h, rd_rem, rd_rel, rd_md} = rdata;
  assign lastidx = cnt_r - CntW'(1);
  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      intv_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      intv_r  <= intv_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    min_r    <= min_nxt;
    stat_r   <= stat_nxt;
    pend_h_r <= pend_h_nxt;
    pend_d_r <= pend_d_nxt;
    if (start && !busy) begin
      op_r  <= in_op;
      h_r   <= in_handle[HandleBits-1:0];
      per_r <= in_period;
      md_r  <= in_timer_mode;
      el_r  <= (in_op == OP_TICK) ? intv_r : in_elapsed;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_op == OP_TICK) begin
            state_nxt = S_UPD_RD;
          end else if (in_op == OP_START) begin
            state_nxt = (cnt_r >= CntW'(MaxTimers)) ? S_FINISH : S_UPD_RD;
          end else begin
            state_nxt = S_FIND_RD;
          end
        end
      end
      S_FIND_RD:  state_nxt = (i_r < cnt_r) ? S_FIND_CHK : S_FINISH;
      S_FIND_CHK: state_nxt = (rd_h == h_r) ? S_UPD_RD : S_FIND_RD;
      S_UPD_RD: begin
        if (i_r < cnt_r) begin
          state_nxt = S_UPD_CHK;
        end else if (op_r == OP_TICK) begin
          state_nxt = S_MIN_RD;
        end else if (op_r == OP_START) begin
          state_nxt = S_APPEND;
        end else begin
          state_nxt = S_TGT_RD;
        end
      end
      S_UPD_CHK: begin
        state_nxt = (rd_rem <= 32'(el_r) && !rd_md[0]) ? S_MOVE_RD : S_UPD_RD;
      end
      S_MOVE_RD:  state_nxt = S_MOVE_WR;
      S_MOVE_WR:  state_nxt = S_UPD_RD;
      S_APPEND:   state_nxt = S_MIN_RD;
      // A target that expired during the update still needs a fresh minimum.
      S_TGT_RD:   state_nxt = (i_r < cnt_r) ? S_TGT_CHK : S_MIN_RD;
      S_TGT_CHK: begin
        if (rd_h != h_r) begin
          state_nxt = S_TGT_RD;
        end else begin
          state_nxt = (op_r == OP_STOP) ? S_MOVE2_RD : S_MIN_RD;
        end
      end
      S_MOVE2_RD: state_nxt = S_MOVE2_WR;
      S_MOVE2_WR: state_nxt = S_MIN_RD;
      S_MIN_RD:   state_nxt = (i_r < cnt_r) ? S_MIN_CHK : S_FINISH;
      S_MIN_CHK:  state_nxt = S_MIN_RD;
      S_FINISH:   state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cnt_nxt    = cnt_r;
    i_nxt      = i_r;
    intv_nxt   = intv_r;
    min_nxt    = min_r;
    stat_nxt   = stat_r;
    pend_nxt   = pend_r;
    pend_h_nxt = pend_h_r;
    pend_d_nxt = pend_d_r;
    we    = 1'b0;
    addr  = i_r[IdxW-1:0];
    wdata = rdata;
    out_valid         = 1'b0;
    out_fired         = pend_r;
    out_fired_handle  = pend_h_r;
    out_deferred      = pend_d_r;
    out_op_status     = stat_r;
    out_next_period   = '0;
    out_timer_running = 1'b0;
    out_last          = 1'b0;
    case (state_r)
      S_IDLE: begin
        i_nxt    = '0;
        min_nxt  = PeriodCap;
        stat_nxt = ST_DONE;
        pend_nxt = 1'b0;
        if (start && in_op == OP_START && cnt_r >= CntW'(MaxTimers)) begin
          stat_nxt = ST_FULL;
        end
      end
      S_FIND_RD: begin
        if (i_r >= cnt_r) begin
          stat_nxt = ST_NOTFOUND;
        end
      end
      S_FIND_CHK: begin
        i_nxt = (rd_h == h_r) ? '0 : i_r + CntW'(1);
      end
      S_UPD_RD: begin
        if (i_r >= cnt_r) begin
          i_nxt = '0;
        end
      end
      S_UPD_CHK: begin
        if (rd_rem <= 32'(el_r)) begin
          if (pend_r) begin
            out_valid = 1'b1;
          end
          pend_nxt   = 1'b1;
          pend_h_nxt = 8'(rd_h);
          pend_d_nxt = rd_md[1];
          if (rd_md[0]) begin
            we    = 1'b1;
            wdata = {rd_h, rd_rel, rd_rel, rd_md};
            i_nxt = i_r + CntW'(1);
          end
        end else begin
          we    = 1'b1;
          wdata = {rd_h, rd_rem - 32'(el_r), rd_rel, rd_md};
          i_nxt = i_r + CntW'(1);
        end
      end
      S_MOVE_RD, S_MOVE2_RD: begin
        addr = lastidx[IdxW-1:0];
      end
      S_MOVE_WR, S_MOVE2_WR: begin
        we      = 1'b1;
        wdata   = rdata;
        cnt_nxt = lastidx;
        if (state_r == S_MOVE2_WR) begin
          i_nxt = '0;
        end
      end
      S_APPEND: begin
        addr    = cnt_r[IdxW-1:0];
        we      = 1'b1;
        wdata   = {h_r, per_r, per_r, md_r};
        cnt_nxt = cnt_r + CntW'(1);
        i_nxt   = '0;
      end
      S_TGT_RD: begin
        if (i_r >= cnt_r) begin
          i_nxt = '0;
        end
      end
      S_TGT_CHK: begin
        if (rd_h != h_r) begin
          i_nxt = i_r + CntW'(1);
        end else if (op_r == OP_RESTART) begin
          we    = 1'b1;
          wdata = {rd_h, rd_rel, rd_rel, rd_md};
          i_nxt = '0;
        end
      end
      S_MIN_CHK: begin
        if (rd_rem < min_r) begin
          min_nxt = rd_rem;
        end
        i_nxt = i_r + CntW'(1);
      end
      S_MIN_RD: begin
        if (i_r >= cnt_r && cnt_r != '0) begin
          intv_nxt = min_r[15:0];
        end
      end
      S_FINISH: begin
        out_valid         = 1'b1;
        out_last          = 1'b1;
        out_next_period   = (cnt_r != '0) ? intv_r : 16'd0;
        out_timer_running = (cnt_r != '0);
        if (!pend_r) begin
          out_fired_handle = '0;
          out_deferred     = 1'b0;
        end
        pend_nxt = 1'b0;
      end
      default: ;
    endcase
    if (!pend_r) begin
      out_fired_handle = '0;
      out_deferred     = 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for multiplexed_timer_table: a directed request table, then random requests,
// checked against a predictor of the timer table. Depends on mtt_pkg and the RTL.
`default_nettype none
module tb;
  import mtt_pkg::*;

  typedef struct packed {
    logic       fired;
    logic [7:0] fired_handle;
    logic       deferred;
    logic [1:0] op_status;
    logic [15:0] next_period;
    logic       timer_running;
    logic       last;
  } res_t;

  typedef struct {
    op_t         op;
    logic [7:0]  handle;
    logic [31:0] period;
    logic [1:0]  mode;
    logic [15:0] elapsed;
    bit          has_res;
    res_t        res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_op = '0;
  logic [7:0] in_handle = '0;
  logic [31:0] in_period = '0;
  logic [1:0] in_timer_mode = '0;
  logic [15:0] in_elapsed = '0;
  logic out_valid, out_fired, out_deferred, out_timer_running, out_last;
  logic [7:0] out_fired_handle;
  logic [1:0] out_op_status;
  logic [15:0] out_next_period;

  multiplexed_timer_table DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_handle(in_handle), .in_period(in_period),
    .in_timer_mode(in_timer_mode), .in_elapsed(in_elapsed),
    .out_valid(out_valid), .out_fired(out_fired), .out_fired_handle(out_fired_handle),
    .out_deferred(out_deferred), .out_op_status(out_op_status),
    .out_next_period(out_next_period), .out_timer_running(out_timer_running),
    .out_last(out_last)
  );

  always #6 clk = ~clk;

  // Predictor state.
  logic [7:0]  tm_handle [MaxTimers];
  logic [31:0] tm_left [MaxTimers];
  logic [31:0] tm_reload [MaxTimers];
  logic [1:0]  tm_mode [MaxTimers];
  int unsigned tm_count;
  logic [31:0] tm_interval;

  res_t pending_results[$];
  res_t step_results[$];
  int errors = 0;
  int results_seen = 0;
  int fires_seen = 0;
  longint cycles = 0;
  int idle_pct = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  task automatic remove_timer(input int unsigned idx);
    tm_handle[idx] = tm_handle[tm_count-1];
    tm_left[idx] = tm_left[tm_count-1];
    tm_reload[idx] = tm_reload[tm_count-1];
    tm_mode[idx] = tm_mode[tm_count-1];
    tm_count--;
  endtask

  task automatic age_timers(input logic [31:0] el);
    res_t r;
    int unsigned i;
    i = 0;
    while (i < tm_count) begin
      if (tm_left[i] <= el) begin
        r = '0;
        r.fired = 1'b1;
        r.fired_handle = tm_handle[i];
        r.deferred = tm_mode[i][1];
        step_results.push_back(r);
        if (tm_mode[i][0]) begin
          tm_left[i] = tm_reload[i];
          i++;
        end else begin
          remove_timer(i);
        end
      end else begin
        tm_left[i] -= el;
        i++;
      end
    end
  endtask

  task automatic update_interval();
    logic [31:0] m;
    m = PeriodCap;
    if (tm_count == 0) return;
    for (int i = 0; i < tm_count; i++) if (tm_left[i] < m) m = tm_left[i];
    tm_interval = m;
  endtask

  function automatic int find_timer(input logic [7:0] h);
    for (int i = 0; i < tm_count; i++) if (tm_handle[i] == h) return i;
    return -1;
  endfunction

  // Works out every result of one request and appends them to pending_results.
  task automatic predict_timers(input op_t op, input logic [7:0] h, input logic [31:0] per,
                                input logic [1:0] md, input logic [15:0] el);
    status_t st;
    res_t r;
    int idx;
    st = ST_DONE;
    step_results.delete();
    if (op == OP_TICK) begin
      age_timers(tm_interval);
      update_interval();
    end else if (op == OP_START) begin
      if (tm_count >= MaxTimers) st = ST_FULL;
      else begin
        age_timers({16'd0, el});
        tm_handle[tm_count] = h;
        tm_left[tm_count] = per;
        tm_reload[tm_count] = per;
        tm_mode[tm_count] = md;
        tm_count++;
        update_interval();
      end
    end else begin
      if (find_timer(h) < 0) st = ST_NOTFOUND;
      else begin
        age_timers({16'd0, el});
        idx = find_timer(h);
        if (idx >= 0) begin
          if (op == OP_RESTART) tm_left[idx] = tm_reload[idx];
          else remove_timer(idx);
        end
        update_interval();
      end
    end
    if (step_results.size() == 0) step_results.push_back('0);
    r = step_results.pop_back();
    r.next_period = (tm_count != 0) ? tm_interval[15:0] : 16'd0;
    r.timer_running = (tm_count != 0);
    r.last = 1'b1;
    step_results.push_back(r);
    foreach (step_results[i]) begin
      step_results[i].op_status = st;
      pending_results.push_back(step_results[i]);
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    res_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      got = '{out_fired, out_fired_handle, out_deferred, out_op_status, out_next_period,
              out_timer_running, out_last};
      results_seen++;
      if (out_fired) fires_seen++;
      if (pending_results.size() == 0) report_mismatch("result with nothing expected");
      else begin
        want = pending_results.pop_front();
        if (got.fired !== want.fired) report_mismatch("fired");
        if (got.fired_handle !== want.fired_handle) report_mismatch("fired_handle");
        if (got.deferred !== want.deferred) report_mismatch("deferred");
        if (got.op_status !== want.op_status) report_mismatch("op_status");
        if (got.next_period !== want.next_period) report_mismatch("next_period");
        if (got.timer_running !== want.timer_running) report_mismatch("timer_running");
        if (got.last !== want.last) report_mismatch("last");
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("timeout: %0d results still expected", pending_results.size());
      $display("[multiplexed_timer_table] ERROR");
      $finish;
    end
  end

  // Issues one request and waits until the block takes it. Start stays high afterwards
  // until the next idle cycle or pause, which is harmless while the block is busy.
  task automatic issue_request(input op_t op, input logic [7:0] h, input logic [31:0] per,
                               input logic [1:0] md, input logic [15:0] el,
                               input bit has_res, input res_t res);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_handle <= h;
    in_period <= per;
    in_timer_mode <= md;
    in_elapsed <= el;
    @(posedge clk);
    while (busy) @(posedge clk);
    // The request is taken at this edge.
    predict_timers(op, h, per, md, el);
    if (has_res && pending_results[$] !== res) report_mismatch("directed row expectation");
  endtask

  function automatic res_t last_res(input status_t st, input logic [15:0] np, input logic run);
    res_t r;
    r = '0;
    r.op_status = st;
    r.next_period = np;
    r.timer_running = run;
    r.last = 1'b1;
    return r;
  endfunction

  row_t rows[$];

  task automatic add_row(input op_t op, input logic [7:0] h, input logic [31:0] per,
                         input logic [1:0] md, input logic [15:0] el,
                         input bit has_res, input res_t res);
    row_t w;
    w.op = op; w.handle = h; w.period = per; w.mode = md; w.elapsed = el;
    w.has_res = has_res; w.res = res;
    rows.push_back(w);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    op_t op;
    logic [7:0] h;
    logic [31:0] per;
    logic [15:0] el;
    res_t none;
    int n;
    none = '0;
    tm_count = 0;
    tm_interval = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: tick, restart and stop of an absent handle.
    add_row(OP_TICK, 8'h00, 32'd0, 2'd0, 16'd0, 1, last_res(ST_DONE, 16'd0, 1'b0));
    add_row(OP_STOP, 8'hff, 32'd0, 2'd0, 16'hfff0, 1, last_res(ST_NOTFOUND, 16'd0, 1'b0));
    add_row(OP_RESTART, 8'h00, 32'd0, 2'd0, 16'd0, 1, last_res(ST_NOTFOUND, 16'd0, 1'b0));
    add_row(OP_START, 8'h01, 32'hffff_ffff, 2'd0, 16'd0, 1,
            last_res(ST_DONE, 16'hfff0, 1'b1));
    add_row(OP_START, 8'hff, 32'd5, 2'd1, 16'd0, 1, last_res(ST_DONE, 16'd5, 1'b1));
    add_row(OP_START, 8'h02, 32'd0, 2'd2, 16'd0, 0, none);  // zero period
    add_row(OP_START, 8'h02, 32'd7, 2'd3, 16'd0, 0, none);  // duplicate handle
    add_row(OP_TICK, 8'h00, 32'd0, 2'd0, 16'd0, 0, none);
    add_row(OP_START, 8'h03, 32'd9, 2'd3, 16'd3, 0, none);
    add_row(OP_START, 8'h04, 32'd100, 2'd0, 16'd0, 0, none);
    add_row(OP_START, 8'h05, 32'd200, 2'd2, 16'd0, 0, none);
    add_row(OP_START, 8'h06, 32'd300, 2'd1, 16'd0, 0, none);
    add_row(OP_START, 8'h07, 32'd400, 2'd0, 16'd0, 0, none);
    add_row(OP_START, 8'h08, 32'd500, 2'd0, 16'd0, 0, none);
    add_row(OP_START, 8'h09, 32'd600, 2'd0, 16'd0, 0, none);  // table full by now
    add_row(OP_RESTART, 8'h02, 32'd0, 2'd0, 16'd1, 0, none);
    add_row(OP_STOP, 8'h04, 32'd0, 2'd0, 16'd100, 0, none);   // target expires first
    add_row(OP_STOP, 8'haa, 32'd0, 2'd0, 16'd0, 0, none);
    add_row(OP_RESTART, 8'hff, 32'd0, 2'd0, 16'hfff0, 0, none);
    add_row(OP_TICK, 8'h00, 32'd0, 2'd0, 16'd0, 0, none);
    foreach (rows[i])
      issue_request(rows[i].op, rows[i].handle, rows[i].period, rows[i].mode,
                    rows[i].elapsed, rows[i].has_res, rows[i].res);
    wait_drained();

    // Random phases: no idling, mostly idle sender, lightly idle sender, then no idling again.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 67 : (ph == 2) ? 15 : 0;
      for (int k = 0; k < 62; k++) begin
        n = $urandom_range(99);
        op = (n < 20) ? OP_TICK : (n < 55) ? OP_START : (n < 78) ? OP_RESTART : OP_STOP;
        // Mostly handles already in the table so restart and stop reach deep.
        if (tm_count != 0 && $urandom_range(3) != 0 && op != OP_START)
          h = tm_handle[$urandom_range(tm_count-1)];
        else if ($urandom_range(3) == 0) h = 8'($urandom_range(255));
        else h = 8'($urandom_range(15));
        case ($urandom_range(4))
          0: per = $urandom;
          1: per = $urandom_range(3);
          default: per = $urandom_range(2000);
        endcase
        if ($urandom_range(9) == 0) per = 32'hffff_ffff;
        case ($urandom_range(3))
          0: el = 16'($urandom_range(16'hfff0));
          1: el = 16'hfff0;
          default: el = 16'($urandom_range(600));
        endcase
        issue_request(op, h, per, 2'($urandom_range(3)), el, 0, none);
        if (k == 30) begin
          start <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
      end
      // Empty the table after the second phase.
      if (ph == 1)
        while (tm_count != 0) issue_request(OP_STOP, tm_handle[0], 32'd0, 2'd0, 16'd0, 0, none);
    end
    wait_drained();

    $display("covered %0d results, %0d expiries, across four idling phases", results_seen,
             fires_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[multiplexed_timer_table] OK");
    end else begin
      $display("[multiplexed_timer_table] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
